// File: rtl/core/fat12_cluster_chain_walker_macros.svh
// assertion macros shared by the walker's checker
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FCW_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define FCW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/fcw_pkg.sv
// types, codes and constants of the cluster chain walker
package fcw_pkg;

    // field widths
    localparam int W_MODE     = 2;
    localparam int W_BYTE     = 8;
    localparam int W_CLUSTER  = 12;
    localparam int W_SIZE     = 32;
    localparam int W_BPS      = 13;
    localparam int W_DBS      = 16;
    localparam int W_IDX      = 13;
    localparam int W_ROW      = 2 * W_CLUSTER;
    localparam int W_CFG_IDX  = 1;
    localparam int W_CFG_DATA = 16;

    localparam int FAT_ENTRIES_DEF = 4096;
    localparam int Q_DEPTH         = 2;

    localparam logic [W_CLUSTER-1:0] END_MARK  = 12'hFF7;
    localparam logic [W_CLUSTER-1:0] FAT_BLANK = 12'hFFF;
    localparam logic [W_BPS-1:0]     BPS_RESET = 13'd512;
    localparam logic [W_DBS-1:0]     DBS_RESET = 16'd31;

    // request modes
    localparam logic [W_MODE-1:0] MODE_LOAD  = 2'd0;
    localparam logic [W_MODE-1:0] MODE_START = 2'd1;
    localparam logic [W_MODE-1:0] MODE_STEP  = 2'd2;

    // queued operations
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_START = 2'd1;
    localparam t_op OP_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_BPS = 1'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_DBS = 1'd1;

    typedef struct packed {
        t_op                  op;
        logic [W_BYTE-1:0]    fat_byte;
        logic [W_CLUSTER-1:0] first_cluster;
        logic [W_SIZE-1:0]    file_size;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        logic [W_BPS-1:0] bps;
        logic [W_DBS-1:0] dbs;
    } t_cfg;

    typedef struct packed {
        logic                 status;
        logic [W_SIZE-1:0]    image_offset;
        logic [W_BPS-1:0]     copy_count;
        logic [W_SIZE-1:0]    file_offset;
        logic [W_CLUSTER-1:0] cluster;
        logic                 last;
    } t_rsp;

endpackage

// File: rtl/core/fcw_if.sv
// request and result channel interfaces
interface fcw_req_if import fcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [W_MODE-1:0]    mode;
    logic [W_BYTE-1:0]    fat_byte;
    logic [W_CLUSTER-1:0] first_cluster;
    logic [W_SIZE-1:0]    file_size;

    modport source (output valid, mode, fat_byte, first_cluster, file_size, input ready);
    modport sink   (input valid, mode, fat_byte, first_cluster, file_size, output ready);
endinterface

interface fcw_rsp_if import fcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [W_SIZE-1:0]    image_offset;
    logic [W_BPS-1:0]     copy_count;
    logic [W_SIZE-1:0]    file_offset;
    logic [W_CLUSTER-1:0] cluster;
    logic                 last;

    modport source (output valid, status, image_offset, copy_count, file_offset, cluster, last,
                    input ready);
    modport sink   (input valid, status, image_offset, copy_count, file_offset, cluster, last,
                    output ready);
endinterface

// File: rtl/core/fcw_ram.sv
// generic single-write, single-read ram with registered read data
module fcw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/fcw_front.sv
// request intake: mode decode and two-entry command queue
module fcw_front import fcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcw_req_if.sink     i_req,
    input  logic        i_pop,
    output t_head       o_head
);
    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_q [Q_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          keep;
    t_op           op;
    logic          push;

    always_comb begin
        keep = 1'b1;
        op   = OP_LOAD;
        unique case (i_req.mode)
            MODE_LOAD:  op = OP_LOAD;
            MODE_START: op = OP_START;
            MODE_STEP:  op = OP_STEP;
            default:    keep = 1'b0;   // unused mode is dropped
        endcase
    end

    assign i_req.ready = (r_cnt != CW'(Q_DEPTH));
    assign push        = i_req.valid & i_req.ready & keep;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wr] <= '{op:            op,
                           fat_byte:      i_req.fat_byte,
                           first_cluster: i_req.first_cluster,
                           file_size:     i_req.file_size};
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];
endmodule

// File: rtl/core/fcw_back.sv
// command execution: table load, chain start and chain step
module fcw_back import fcw_pkg::*; #(
    parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    input  t_cfg        i_cfg,
    fcw_rsp_if.source   o_rsp
);
    localparam int LW   = $clog2(FAT_ENTRIES + 1);
    localparam int ROWS = (FAT_ENTRIES + 1) / 2;
    localparam int AW   = $clog2(ROWS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_STEP = 1'b1;

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic                 r_state, n_state;
    logic [LW-1:0]        r_load_idx, n_load_idx;
    logic [1:0]           r_phase, n_phase;
    logic [15:0]          r_held, n_held;
    logic [W_CLUSTER-1:0] r_cl, n_cl;
    logic [W_SIZE-1:0]    r_rem, n_rem;
    logic [W_SIZE-1:0]    r_foff, n_foff;
    logic                 r_active, n_active;
    logic                 r_hi, n_hi;
    logic                 r_written, n_written;
    logic [W_SIZE-1:0]    r_prod, n_prod;
    logic [W_BPS-1:0]     r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    t_rsp                 r_out, n_out;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [W_ROW-1:0]     wdata;
    logic                 re;
    logic [W_ROW-1:0]     rdata;
    logic [LW:0]          idx_sum;
    logic [W_DBS:0]       base_sum;
    logic [29:0]          prod;
    logic [W_CLUSTER-1:0] nxt;
    logic                 fin;
    logic                 out_free;

    fcw_ram #(
        .WIDTH (W_ROW),
        .DEPTH (ROWS)
    ) u_fat_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_cl[AW:1]),
        .o_rdata (rdata)
    );

    assign idx_sum  = {1'b0, r_load_idx} + (LW + 1)'(2);
    assign base_sum = {1'b0, i_cfg.dbs} + (W_DBS + 1)'(r_cl);
    assign prod     = {17'd0, i_cfg.bps} * {13'd0, base_sum};
    assign waddr    = r_load_idx[AW:1];
    assign wdata    = {i_head.cmd.fat_byte, r_held};

    // entries beyond the fill count read as FAT_BLANK instead of the unreset ram data
    assign nxt      = r_written ? (r_hi ? rdata[W_ROW-1:W_CLUSTER] : rdata[W_CLUSTER-1:0])
                                : FAT_BLANK;
    assign fin      = (nxt >= END_MARK);
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_load_idx  = r_load_idx;
        n_phase     = r_phase;
        n_held      = r_held;
        n_cl        = r_cl;
        n_rem       = r_rem;
        n_foff      = r_foff;
        n_active    = r_active;
        n_hi        = r_hi;
        n_written   = r_written;
        n_prod      = r_prod;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        we          = 1'b0;
        re          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    unique case (i_head.cmd.op)
                        OP_LOAD: begin
                            o_pop = 1'b1;
                            unique case (r_phase)
                                PH_0: begin
                                    n_held  = {8'd0, i_head.cmd.fat_byte};
                                    n_phase = PH_1;
                                end
                                PH_1: begin
                                    n_held  = {i_head.cmd.fat_byte, r_held[7:0]};
                                    n_phase = PH_2;
                                end
                                default: begin
                                    we      = (r_load_idx < LW'(FAT_ENTRIES));
                                    n_phase = PH_0;
                                    if (idx_sum > (LW + 1)'(FAT_ENTRIES)) begin
                                        n_load_idx = LW'(FAT_ENTRIES);
                                    end else begin
                                        n_load_idx = idx_sum[LW-1:0];
                                    end
                                end
                            endcase
                        end
                        OP_START: begin
                            o_pop    = 1'b1;
                            n_cl     = i_head.cmd.first_cluster;
                            n_rem    = i_head.cmd.file_size;
                            n_foff   = '0;
                            n_active = (i_head.cmd.first_cluster < END_MARK);
                        end
                        OP_STEP: begin
                            n_written = ({1'b0, r_cl} < W_IDX'(r_load_idx));
                            re        = n_written;
                            n_hi      = r_cl[0];
                            n_prod    = {2'd0, prod};
                            n_cnt     = ({19'd0, i_cfg.bps} < r_rem) ? i_cfg.bps
                                                                    : r_rem[W_BPS-1:0];
                            n_state   = S_STEP;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            default: begin
                if (out_free) begin
                    o_pop       = 1'b1;
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_active) begin
                        n_out    = '{status:       1'b0,
                                     image_offset: r_prod,
                                     copy_count:   r_cnt,
                                     file_offset:  r_foff,
                                     cluster:      r_cl,
                                     last:         fin};
                        n_rem    = r_rem - {19'd0, r_cnt};
                        n_foff   = r_foff + {19'd0, i_cfg.bps};
                        n_cl     = nxt;
                        n_active = !fin;
                    end else begin
                        n_out        = '0;
                        n_out.status = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_idx  <= '0;
            r_phase     <= PH_0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_idx  <= n_load_idx;
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_held    <= n_held;
        r_cl      <= n_cl;
        r_rem     <= n_rem;
        r_foff    <= n_foff;
        r_hi      <= n_hi;
        r_written <= n_written;
        r_prod    <= n_prod;
        r_cnt     <= n_cnt;
        r_out     <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.image_offset = r_out.image_offset;
    assign o_rsp.copy_count   = r_out.copy_count;
    assign o_rsp.file_offset  = r_out.file_offset;
    assign o_rsp.cluster      = r_out.cluster;
    assign o_rsp.last         = r_out.last;
endmodule

// File: rtl/core/fat12_cluster_chain_walker.sv
// fat12 cluster chain walker top level
//
// channel   dir  handshake      payload
// i_req     in   valid/ready    mode, fat_byte, first_cluster, file_size
// o_rsp     out  valid/ready    status, image_offset, copy_count, file_offset, cluster, last
// cfg       in   i_cfg_we only  i_cfg_idx, i_cfg_data
//
// a load or start request executes in the idle state; a step issues the synchronous fat ram read
// there and then, in the step state, selects the entry and updates the chain
// a kept request passes through the two-entry queue before it executes
// reset needs no clearing pass; table rows past the fill count read as 0xfff
// a stalled result holds in the output register, the next step then waits and the queue fills,
// and i_req.ready drops once both queue entries are taken
module fat12_cluster_chain_walker import fcw_pkg::*; #(
    parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcw_req_if.sink               i_req,
    fcw_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [W_CFG_DATA-1:0] i_cfg_data
);
    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [W_BPS-1:0] r_bps, n_bps;
    logic [W_DBS-1:0] r_dbs, n_dbs;
    t_cfg             cfg;

    // queue head and pop between intake and execution
    t_head head;
    logic  pop;

    always_comb begin
        n_bps = r_bps;
        n_dbs = r_dbs;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BPS: n_bps = i_cfg_data[W_BPS-1:0];
                CFG_DBS: n_dbs = i_cfg_data[W_DBS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps <= BPS_RESET;
            r_dbs <= DBS_RESET;
        end else begin
            r_bps <= n_bps;
            r_dbs <= n_dbs;
        end
    end

    assign cfg = '{bps: r_bps, dbs: r_dbs};

    // intake: decode mode, drop unused codes, queue the rest
    fcw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_head  (head)
    );

    // execution: table fill, chain start, chain step with registered result
    fcw_back #(
        .FAT_ENTRIES (FAT_ENTRIES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (cfg),
        .o_rsp   (o_rsp)
    );
endmodule

// File: rtl/core/fcw_checker.sv
// port-level checks of the walker, bound to the top level
`include "fat12_cluster_chain_walker_macros.svh"

module fcw_checker import fcw_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic                 i_status,
    input logic [W_SIZE-1:0]    i_image_offset,
    input logic [W_BPS-1:0]     i_copy_count,
    input logic [W_SIZE-1:0]    i_file_offset,
    input logic [W_CLUSTER-1:0] i_cluster,
    input logic                 i_last
);
    // a stalled result keeps its payload
    `FCW_ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status) && $stable(i_image_offset) && $stable(i_copy_count) && $stable(i_file_offset) && $stable(i_cluster) && $stable(i_last)), "result changed while stalled")

    // a no-chain result carries only its status
    `FCW_ASSERT_NEVER(a_idle_zero, i_clk, i_rst_n, i_rsp_valid && i_status && (i_image_offset != '0 || i_copy_count != '0 || i_file_offset != '0 || i_cluster != '0 || i_last), "no-chain result with nonzero fields")

    // out of reset the queue is open and no result is pending
    `FCW_ASSERT_CLK(a_reset_state, i_clk, i_rst_n, $past(!i_rst_n) |-> (i_req_ready && !i_rsp_valid), "bad state after reset")
endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_image_offset (o_rsp.image_offset),
    .i_copy_count   (o_rsp.copy_count),
    .i_file_offset  (o_rsp.file_offset),
    .i_cluster      (o_rsp.cluster),
    .i_last         (o_rsp.last)
);

// File: test/fat12_cluster_chain_walker_test.sv
// self-checking testbench for the fat12 cluster chain walker
`timescale 1ns / 100ps

module fat12_cluster_chain_walker_test import fcw_pkg::*; ();

    // a small table so that full loads, dropped bytes and clusters past the
    // table all fit in a short run
    localparam int TB_FAT_ENTRIES = 256;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int TAIL_CYCLES    = 16;
    localparam int PRINT_CAP      = 60;

    // spare request code that the block must ignore
    localparam logic [W_MODE-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [W_MODE-1:0]    mode;
        logic [W_BYTE-1:0]    fat_byte;
        logic [W_CLUSTER-1:0] first_cluster;
        logic [W_SIZE-1:0]    file_size;
    } t_walk_req;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [W_CFG_IDX-1:0]  i_cfg_idx;
    logic [W_CFG_DATA-1:0] i_cfg_data;

    fcw_req_if req_bus ();
    fcw_rsp_if rsp_bus ();

    fat12_cluster_chain_walker #(
        .FAT_ENTRIES(TB_FAT_ENTRIES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // request backlog for the driver, sector results still owed by the block
    t_walk_req req_backlog[$];
    t_rsp      sector_q[$];

    int cycle_count;
    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;

    // shadow of the block: table, loader, chain and registers
    logic [W_CLUSTER-1:0] fat_shadow [TB_FAT_ENTRIES];
    logic [W_IDX-1:0]     ld_idx;
    logic [1:0]           ld_phase;
    logic [15:0]          ld_held;
    logic [W_CLUSTER-1:0] cur_cl;
    logic [W_SIZE-1:0]    left_bytes;
    logic [W_SIZE-1:0]    file_pos;
    logic                 walking;
    logic [W_BPS-1:0]     sec_bytes;
    logic [W_DBS-1:0]     base_sec;

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic log_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic logic [W_CLUSTER-1:0] read_fat(input logic [W_CLUSTER-1:0] cl);
        if (cl < TB_FAT_ENTRIES)
            return fat_shadow[cl];
        return FAT_BLANK;
    endfunction

    function automatic void write_fat(input logic [W_IDX-1:0] idx,
                                      input logic [W_CLUSTER-1:0] val);
        if (idx < TB_FAT_ENTRIES)
            fat_shadow[idx] = val;
    endfunction

    // advance the shadow by one accepted request; a step owes one result
    task automatic apply_request(input t_walk_req r);
        t_rsp                 sec;
        logic [W_CLUSTER-1:0] nxt;
        logic [W_BPS-1:0]     cnt;
        logic                 fin;
        sec = '0;
        case (r.mode)
            MODE_LOAD: begin
                if (ld_phase == 2'd0) begin
                    ld_held  = {8'h00, r.fat_byte};
                    ld_phase = 2'd1;
                end else if (ld_phase == 2'd1) begin
                    ld_held  = {r.fat_byte, ld_held[7:0]};
                    ld_phase = 2'd2;
                end else begin
                    // third byte of a group completes two packed entries
                    write_fat(ld_idx, {ld_held[11:8], ld_held[7:0]});
                    write_fat(ld_idx + 13'd1, {r.fat_byte, ld_held[15:12]});
                    ld_idx = ld_idx + 13'd2;
                    if (ld_idx > TB_FAT_ENTRIES)
                        ld_idx = W_IDX'(TB_FAT_ENTRIES);
                    ld_phase = 2'd0;
                end
            end
            MODE_START: begin
                cur_cl     = r.first_cluster;
                left_bytes = r.file_size;
                file_pos   = '0;
                walking    = (r.first_cluster < END_MARK);
            end
            MODE_STEP: begin
                if (!walking) begin
                    sec.status = 1'b1;
                end else begin
                    nxt = read_fat(cur_cl);
                    cnt = ({19'd0, sec_bytes} < left_bytes) ? sec_bytes : left_bytes[W_BPS-1:0];
                    fin = (nxt >= END_MARK);
                    sec.image_offset = 32'(sec_bytes) * (32'(base_sec) + 32'(cur_cl));
                    sec.copy_count   = cnt;
                    sec.file_offset  = file_pos;
                    sec.cluster      = cur_cl;
                    sec.last         = fin;
                    left_bytes = left_bytes - 32'(cnt);
                    file_pos   = file_pos + 32'(sec_bytes);
                    cur_cl     = nxt;
                    walking    = !fin;
                end
                sector_q.push_back(sec);
            end
            default: ;
        endcase
    endtask

    // request driver: holds a request until accepted, idles at random between requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                apply_request(req_backlog.pop_front());
            if (!req_bus.valid || req_bus.ready) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_bus.valid         <= 1'b1;
                    req_bus.mode          <= req_backlog[0].mode;
                    req_bus.fat_byte      <= req_backlog[0].fat_byte;
                    req_bus.first_cluster <= req_backlog[0].first_cluster;
                    req_bus.file_size     <= req_backlog[0].file_size;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_sector(input t_rsp got);
        t_rsp want;
        if (sector_q.size() == 0) begin
            log_mismatch("result with no request pending");
        end else begin
            want = sector_q.pop_front();
            if (got.status != want.status)
                log_mismatch($sformatf("status %0d want %0d", got.status, want.status));
            if (got.image_offset != want.image_offset)
                log_mismatch($sformatf("image_offset %0h want %0h",
                                       got.image_offset, want.image_offset));
            if (got.copy_count != want.copy_count)
                log_mismatch($sformatf("copy_count %0d want %0d",
                                       got.copy_count, want.copy_count));
            if (got.file_offset != want.file_offset)
                log_mismatch($sformatf("file_offset %0h want %0h",
                                       got.file_offset, want.file_offset));
            if (got.cluster != want.cluster)
                log_mismatch($sformatf("cluster %0h want %0h", got.cluster, want.cluster));
            if (got.last != want.last)
                log_mismatch($sformatf("last %0d want %0d", got.last, want.last));
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready)
                compare_sector('{status:       rsp_bus.status,
                                 image_offset: rsp_bus.image_offset,
                                 copy_count:   rsp_bus.copy_count,
                                 file_offset:  rsp_bus.file_offset,
                                 cluster:      rsp_bus.cluster,
                                 last:         rsp_bus.last});
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_req(input logic [W_MODE-1:0] m, input logic [W_BYTE-1:0] b,
                            input logic [W_CLUSTER-1:0] c, input logic [W_SIZE-1:0] s);
        t_walk_req r;
        r.mode          = m;
        r.fat_byte      = b;
        r.first_cluster = c;
        r.file_size     = s;
        req_backlog.push_back(r);
    endtask

    // unused fields of every request carry random bits
    task automatic push_load(input logic [W_BYTE-1:0] b);
        push_req(MODE_LOAD, b, W_CLUSTER'($urandom), $urandom);
    endtask

    task automatic push_start(input logic [W_CLUSTER-1:0] c, input logic [W_SIZE-1:0] s);
        push_req(MODE_START, W_BYTE'($urandom), c, s);
    endtask

    task automatic push_step();
        push_req(MODE_STEP, W_BYTE'($urandom), W_CLUSTER'($urandom), $urandom);
    endtask

    task automatic push_noise();
        push_req(MODE_SPARE, W_BYTE'($urandom), W_CLUSTER'($urandom), $urandom);
    endtask

    // table entry: sequential links, jumps, end marks and links past the table
    function automatic logic [W_CLUSTER-1:0] pick_entry(input int idx);
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return (idx + 1 < TB_FAT_ENTRIES) ? W_CLUSTER'(idx + 1) : END_MARK;
        if (r < 60)
            return W_CLUSTER'($urandom_range(TB_FAT_ENTRIES - 1, 2));
        if (r < 78)
            return END_MARK + W_CLUSTER'($urandom_range(8));
        if (r < 88)
            return W_CLUSTER'($urandom_range(END_MARK - 1, TB_FAT_ENTRIES));
        return W_CLUSTER'($urandom);
    endfunction

    function automatic logic [W_CLUSTER-1:0] pick_cluster();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return W_CLUSTER'($urandom_range(TB_FAT_ENTRIES - 1));
        if (r < 80)
            return END_MARK + W_CLUSTER'($urandom_range(8));
        if (r < 90)
            return W_CLUSTER'($urandom_range(END_MARK - 1, TB_FAT_ENTRIES));
        return W_CLUSTER'($urandom);
    endfunction

    // file sizes around sector multiples, tiny, huge and the extremes
    function automatic logic [W_SIZE-1:0] pick_size(input logic [W_BPS-1:0] bps);
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return $urandom_range(4 * bps + 3);
        if (r < 50)
            return $urandom_range(16);
        if (r < 70)
            return $urandom;
        if (r < 80)
            return '0;
        if (r < 90)
            return '1;
        return 32'(bps) * $urandom_range(1, 6) + $urandom_range(2) - 1;
    endfunction

    // fill the rest of the table with linked chains, then a few bytes that fall off the end
    task automatic push_table_load();
        logic [W_CLUSTER-1:0] e0;
        logic [W_CLUSTER-1:0] e1;
        for (int i = 2; i < TB_FAT_ENTRIES; i += 2) begin
            e0 = pick_entry(i);
            e1 = pick_entry(i + 1);
            push_load(e0[7:0]);
            push_load({e1[3:0], e0[11:8]});
            push_load(e1[11:4]);
        end
        repeat ($urandom_range(8, 4)) push_load(W_BYTE'($urandom));
    endtask

    // mostly well-formed walks: a start and a run of steps, sometimes past the chain end;
    // the rest is stray steps, ignored requests and loads
    task automatic push_walks(input int n);
        int done;
        int r;
        int k;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 75) begin
                push_start(pick_cluster(), pick_size(sec_bytes));
                k = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(10, 1);
                repeat (k) begin
                    if ($urandom_range(19) == 0)
                        push_noise();
                    push_step();
                end
                done += k + 1;
            end else if (r < 85) begin
                k = $urandom_range(3, 1);
                repeat (k) push_step();
                done += k;
            end else if (r < 92) begin
                push_noise();
            end else begin
                k = $urandom_range(3, 1);
                repeat (k) push_load(W_BYTE'($urandom));
                done += k;
            end
        end
    endtask

    // corner cases on the reset table and register values
    task automatic push_directed();
        push_step();                           // step with no chain
        push_req(MODE_SPARE, '1, '1, '1);      // ignored request, all ones
        push_start(END_MARK, 32'd100);         // empty chain at the end mark
        push_step();
        push_start(FAT_BLANK, '1);
        push_start('0, '1);                    // cluster zero, largest file
        push_step();
        push_step();                           // chain already ended
        push_start(12'hFF6, '0);               // cluster past the table, empty file
        push_step();
        push_load(8'hF6);                      // entry 0 = 0xff6, entry 1 = 0x000
        push_load(8'h0F);
        push_load(8'h00);
        push_start(12'd1, 32'd1000);           // 1 -> 0 -> 0xff6 -> end
        push_step();
        push_step();
        push_step();
        push_step();
        push_start(12'd1, '0);
        push_req(MODE_SPARE, '0, '0, '0);
        push_step();
        push_start('0, 32'd5);
        push_step();
    endtask

    // register writes only while the block is idle
    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input logic [W_CFG_DATA-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_BPS)
            sec_bytes = data[W_BPS-1:0];
        else
            base_sec = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait out every queued request and owed result, then the pipeline depth
    task automatic drain();
        while (req_backlog.size() != 0 || req_bus.valid || sector_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [W_BPS-1:0] bps, input logic [W_DBS-1:0] dbs,
                             input int s_idle, input int r_idle, input int n);
        write_reg(CFG_BPS, {3'($urandom_range(7)), bps});  // upper data bits are dropped
        write_reg(CFG_DBS, dbs);
        @(negedge i_clk);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        push_walks(n);
        drain();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_bus.valid  = 1'b0;
        req_bus.mode   = MODE_LOAD;
        req_bus.fat_byte      = '0;
        req_bus.first_cluster = '0;
        req_bus.file_size     = '0;
        rsp_bus.ready  = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        send_idle_pct  = 22;
        recv_idle_pct  = 70;
        for (int i = 0; i < TB_FAT_ENTRIES; i++)
            fat_shadow[i] = FAT_BLANK;
        ld_idx     = '0;
        ld_phase   = '0;
        ld_held    = '0;
        cur_cl     = '0;
        left_bytes = '0;
        file_pos   = '0;
        walking    = 1'b0;
        sec_bytes  = BPS_RESET;
        base_sec   = DBS_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, table loaded once; sender idles lightly, receiver heavily
        @(negedge i_clk);
        push_directed();
        push_table_load();
        push_walks(140);
        drain();

        run_phase(13'd1, 16'd0, 22, 70, 140);
        run_phase(13'd4096, 16'hFFFF, 22, 70, 140);
        // idling swapped: sender heavy, receiver light
        run_phase(13'd0, W_DBS'($urandom), 70, 22, 110);
        run_phase(13'h1FFF, W_DBS'($urandom), 70, 22, 140);
        // no idling on either side
        run_phase(W_BPS'($urandom_range(4096, 1)), W_DBS'($urandom), 0, 0, 160);
        run_phase(BPS_RESET, DBS_RESET, 0, 0, 160);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: fat12_cluster_chain_walker.f
+incdir+rtl/core
rtl/core/fcw_pkg.sv
rtl/core/fcw_if.sv
rtl/core/fcw_ram.sv
rtl/core/fcw_front.sv
rtl/core/fcw_back.sv
rtl/core/fat12_cluster_chain_walker.sv
rtl/core/fcw_checker.sv
test/fat12_cluster_chain_walker_test.sv
